FILE: hdl/bac_pkg.sv
// Package for the BCD alarm clock: time layout, command codes and the
// BCD digit carry helpers. No dependencies; used by bcd_alarm_clock_top.
package bac_pkg;

  // Digit limits of a 24-hour BCD clock.
  localparam logic [3:0] DIGIT_MAX       = 4'd9;
  localparam logic [3:0] TENS_MAX        = 4'd5;
  localparam logic [1:0] HOUR_TENS_LAST  = 2'd2;
  localparam logic [3:0] HOUR_UNITS_LAST = 4'd3;

  localparam int TIME_W = 22;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_TICKS_PER_SECOND = 2'd0,
    CFG_SNOOZE_MINUTES   = 2'd1,
    CFG_ALARM_TIME       = 2'd2
  } cfg_idx_t;

  // Input item command codes; the two spare codes do nothing.
  typedef enum logic [2:0] {
    CMD_TICK          = 3'd0,
    CMD_SET_TIME      = 3'd1,
    CMD_ALARM_ENABLE  = 3'd2,
    CMD_ALARM_DISABLE = 3'd3,
    CMD_SNOOZE        = 3'd4,
    CMD_CANCEL        = 3'd5
  } cmd_t;

  // Packed BCD hhmmss, hours tens in the top two bits.
  typedef struct packed {
    logic [1:0] h_tens;
    logic [3:0] h_units;
    logic [3:0] m_tens;
    logic [3:0] m_units;
    logic [3:0] s_tens;
    logic [3:0] s_units;
  } bcd_time_t;

  // A time after a carry step, with the midnight wrap flag.
  typedef struct packed {
    bcd_time_t t;
    logic      midnight;
  } time_step_t;

  // One result item.
  typedef struct packed {
    bcd_time_t time_now;
    logic      time_valid;
    logic      alarm_armed;
    logic      alarm_ringing;
  } result_t;

  // Advance minutes tens by one, carrying into the hours. A digit at or past
  // its limit rolls to zero; 23 wraps to 00 and reports midnight.
  function automatic time_step_t add_ten_minutes(input bcd_time_t t);
    time_step_t r;
    r.t        = t;
    r.midnight = 1'b0;
    if (t.m_tens >= TENS_MAX) begin
      r.t.m_tens = 4'd0;
      if (t.h_tens == HOUR_TENS_LAST && t.h_units >= HOUR_UNITS_LAST) begin
        r.t.h_units = 4'd0;
        r.t.h_tens  = 2'd0;
        r.midnight  = 1'b1;
      end else if (t.h_units >= DIGIT_MAX) begin
        r.t.h_units = 4'd0;
        r.t.h_tens  = t.h_tens + 2'd1;
      end else begin
        r.t.h_units = t.h_units + 4'd1;
      end
    end else begin
      r.t.m_tens = t.m_tens + 4'd1;
    end
    return r;
  endfunction

  // Advance the time by one second.
  function automatic time_step_t add_second(input bcd_time_t t);
    time_step_t r;
    r.t        = t;
    r.midnight = 1'b0;
    if (t.s_units >= DIGIT_MAX) begin
      r.t.s_units = 4'd0;
      if (t.s_tens >= TENS_MAX) begin
        r.t.s_tens = 4'd0;
        if (t.m_units >= DIGIT_MAX) begin
          r.t.m_units = 4'd0;
          r = add_ten_minutes(r.t);
        end else begin
          r.t.m_units = t.m_units + 4'd1;
        end
      end else begin
        r.t.s_tens = t.s_tens + 4'd1;
      end
    end else begin
      r.t.s_units = t.s_units + 4'd1;
    end
    return r;
  endfunction

endpackage

FILE: hdl/bcd_alarm_clock_top.sv
// Top level of the BCD alarm clock: clock state, alarm logic, configuration
// registers and the two-entry result buffer. Depends on bac_pkg.

// The clock takes one command item per cycle and returns one result item per
// command, holding the time after the command, the time-set mark and the
// armed and ringing flags. Each item is worked in the cycle it is accepted:
// the BCD increment, the snooze add (at most three carries into minutes tens)
// and the alarm compare sit between the state registers and the result
// register. A result register with one skid entry behind it keeps the input
// open while a finished result waits; in_stall rises only when both are full.
// Configuration writes are always taken (cfg_ready is tied high); indexes past
// the register list are ignored. Writes are meant to arrive while no item is
// in flight.
module bcd_alarm_clock_top
  import bac_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Command items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_command,
  input  logic [TIME_W-1:0]    in_new_time,
  // Result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [TIME_W-1:0]    out_time_now,
  output logic                 out_time_valid,
  output logic                 out_alarm_armed,
  output logic                 out_alarm_ringing,
  // Configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [TIME_W-1:0]    cfg_data
);

  // Configuration registers.
  logic [15:0] ticks_per_sec_r;
  logic [3:0]  snooze_min_r;
  bcd_time_t   alarm_time_r;

  // Clock state.
  logic [15:0] tick_count_r, tick_count_nxt;
  bcd_time_t   time_r, time_nxt;
  bcd_time_t   snooze_target_r, snooze_target_nxt;
  logic        valid_flag_r, valid_flag_nxt;
  logic        armed_r, armed_nxt;
  logic        ringing_r, ringing_nxt;
  logic        canceled_r, canceled_nxt;
  logic        snooze_act_r, snooze_act_nxt;

  // Result buffer.
  result_t     out_r, skid_r, result;
  logic        out_valid_r, skid_valid_r;

  logic        in_accept, out_take;

  // Datapath temporaries.
  logic [15:0] tick_inc;
  time_step_t  sec_step;
  logic [4:0]  snz_sum;
  logic [1:0]  snz_carries;
  time_step_t  snz_step1, snz_step2, snz_step3;
  bcd_time_t   snz_time;
  logic [4:0]  snz_units;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_sec_r <= 16'd5;
      snooze_min_r    <= 4'd0;
      alarm_time_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TICKS_PER_SECOND: ticks_per_sec_r <= cfg_data[15:0];
        CFG_SNOOZE_MINUTES:   snooze_min_r    <= cfg_data[3:0];
        CFG_ALARM_TIME:       alarm_time_r    <= bcd_time_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // One-second advance and the snooze target, both from the current time.
  always_comb begin
    tick_inc = tick_count_r + 16'd1;
    sec_step = add_second(time_r);

    snz_sum = {1'b0, time_r.m_units} + {1'b0, snooze_min_r};
    if (snz_sum >= 5'd30) begin
      snz_carries = 2'd3;
    end else if (snz_sum >= 5'd20) begin
      snz_carries = 2'd2;
    end else if (snz_sum >= 5'd10) begin
      snz_carries = 2'd1;
    end else begin
      snz_carries = 2'd0;
    end
    snz_step1 = add_ten_minutes(time_r);
    snz_step2 = add_ten_minutes(snz_step1.t);
    snz_step3 = add_ten_minutes(snz_step2.t);
    case (snz_carries)
      2'd1:    snz_time = snz_step1.t;
      2'd2:    snz_time = snz_step2.t;
      2'd3:    snz_time = snz_step3.t;
      default: snz_time = time_r;
    endcase
    snz_units        = snz_sum - 5'd10 * {3'b000, snz_carries};
    snz_time.m_units = snz_units[3:0];
  end

  // Next state for the command item at the input.
  always_comb begin
    tick_count_nxt    = tick_count_r;
    time_nxt          = time_r;
    snooze_target_nxt = snooze_target_r;
    valid_flag_nxt    = valid_flag_r;
    armed_nxt         = armed_r;
    ringing_nxt       = ringing_r;
    canceled_nxt      = canceled_r;
    snooze_act_nxt    = snooze_act_r;
    case (cmd_t'(in_command))
      CMD_TICK: begin
        if (tick_inc >= ticks_per_sec_r) begin
          tick_count_nxt = 16'd0;
          time_nxt       = sec_step.t;
          if (sec_step.midnight) begin
            canceled_nxt = 1'b0;
          end
        end else begin
          tick_count_nxt = tick_inc;
        end
        // Alarm compare, or snooze compare while a snooze runs.
        if (armed_r && !canceled_nxt && !snooze_act_r && time_nxt == alarm_time_r) begin
          ringing_nxt = 1'b1;
        end
        if (snooze_act_r && time_nxt == snooze_target_r) begin
          ringing_nxt    = 1'b1;
          snooze_act_nxt = 1'b0;
        end
      end
      CMD_SET_TIME: begin
        valid_flag_nxt = 1'b1;
        time_nxt       = bcd_time_t'(in_new_time);
      end
      CMD_ALARM_ENABLE:  armed_nxt = 1'b1;
      CMD_ALARM_DISABLE: armed_nxt = 1'b0;
      CMD_SNOOZE: begin
        if (ringing_r && snooze_min_r != 4'd0) begin
          snooze_target_nxt = snz_time;
          ringing_nxt       = 1'b0;
          snooze_act_nxt    = 1'b1;
        end
      end
      CMD_CANCEL: begin
        if (ringing_r) begin
          ringing_nxt  = 1'b0;
          canceled_nxt = 1'b1;
        end
      end
      default: ;
    endcase
    result.time_now      = time_nxt;
    result.time_valid    = valid_flag_nxt;
    result.alarm_armed   = armed_nxt;
    result.alarm_ringing = ringing_nxt;
  end

  // State registers, updated when an item is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r    <= '0;
      time_r          <= '0;
      snooze_target_r <= '0;
      valid_flag_r    <= 1'b0;
      armed_r         <= 1'b0;
      ringing_r       <= 1'b0;
      canceled_r      <= 1'b0;
      snooze_act_r    <= 1'b0;
    end else if (in_accept) begin
      tick_count_r    <= tick_count_nxt;
      time_r          <= time_nxt;
      snooze_target_r <= snooze_target_nxt;
      valid_flag_r    <= valid_flag_nxt;
      armed_r         <= armed_nxt;
      ringing_r       <= ringing_nxt;
      canceled_r      <= canceled_nxt;
      snooze_act_r    <= snooze_act_nxt;
    end
  end

  // Result register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_accept) begin
      if (!out_valid_r || out_take) begin
        out_r       <= result;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= result;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_time_now      = out_r.time_now;
  assign out_time_valid    = out_r.time_valid;
  assign out_alarm_armed   = out_r.alarm_armed;
  assign out_alarm_ringing = out_r.alarm_ringing;

endmodule
